### design/esched_pkg.sv
`default_nettype none
package esched_pkg;

	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 8;
	localparam int DUR_W    = 16;
	localparam int TIME_W   = 32;
	localparam int CMD_W    = 3;
	localparam int PERIOD_W = 16;
	localparam int BASE_W   = 10;
	localparam int SHIFT_W  = 4;
	localparam int ACTIVE_W = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_UPLOAD = 2'd0,
		ACT_PLAY   = 2'd1,
		ACT_STOP   = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCEPTED = 3'd0,
		CMD_UPLOAD   = 3'd1,
		CMD_PLAY     = 3'd2,
		CMD_STOP     = 3'd3,
		CMD_BACKOFF  = 3'd4,
		CMD_REJECTED = 3'd5
	} command_t;

	typedef enum logic [2:0] {
		KIND_REJECT  = 3'd0,
		KIND_UPLOAD  = 3'd1,
		KIND_PLAY    = 3'd2,
		KIND_HALT    = 3'd3,
		KIND_STOP    = 3'd4,
		KIND_BACKOFF = 3'd5,
		KIND_WALK    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  count;
		logic [DUR_W-1:0]    dur;
		logic [TIME_W-1:0]   now;
	} item_t;

	typedef struct packed {
		command_t             command;
		logic [SLOT_W-1:0]    effect_slot;
		logic [PERIOD_W-1:0]  next_period_ms;
		logic                 keep_running;
		logic                 last;
	} result_t;

endpackage
`default_nettype wire

### design/esched_front.sv
`default_nettype none
module esched_front #(
	parameter int SLOTS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [esched_pkg::ACTION_W-1:0] action,
	input  wire logic [esched_pkg::SLOT_W-1:0]   slot,
	input  wire logic [esched_pkg::COUNT_W-1:0]  repeat_count,
	input  wire logic [esched_pkg::DUR_W-1:0]    duration_ms,
	input  wire logic                            zero_period_periodic,
	input  wire logic [esched_pkg::TIME_W-1:0]   now_ms,
	input  wire logic                            link_busy,
	output esched_pkg::item_t                    item,
	output logic                                 item_valid,
	input  wire logic                            item_pop
);
	import esched_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	item_t              in_item;
	logic               in_range;
	logic               wr_en;
	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign in_range = {1'b0, slot} < (SLOT_W+1)'(SLOTS);

	always_comb begin
		in_item.slot  = slot;
		in_item.count = repeat_count;
		in_item.dur   = duration_ms;
		in_item.now   = now_ms;
		in_item.kind  = KIND_REJECT;
		case (action_t'(action))
			ACT_UPLOAD: begin
				if (in_range && !zero_period_periodic) in_item.kind = KIND_UPLOAD;
			end
			ACT_PLAY: begin
				if (in_range) in_item.kind = (repeat_count != '0) ? KIND_PLAY : KIND_HALT;
			end
			ACT_STOP: begin
				if (in_range) in_item.kind = KIND_STOP;
			end
			ACT_TICK: begin
				in_item.kind = link_busy ? KIND_BACKOFF : KIND_WALK;
			end
			default: in_item.kind = KIND_REJECT;
		endcase
	end

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (item_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({wr_en, item_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> (count_q != '0))
		else $error("item queue read while empty");
`endif

endmodule
`default_nettype wire

### design/esched_back.sv
`default_nettype none
module esched_back #(
	parameter int SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [esched_pkg::BASE_W-1:0] cfg_wdata,
	input  wire esched_pkg::item_t             item,
	input  wire logic                          item_valid,
	output logic                               item_pop,
	output esched_pkg::result_t                res,
	output logic                               res_push,
	input  wire logic                          res_full
);
	import esched_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int WIDE_W = BASE_W + (1 << SHIFT_W) - 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPIRE = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_FINAL  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [BASE_W-1:0]    base_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [ACTIVE_W-1:0]  active_q;
	logic [IDX_W-1:0]     highest_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TIME_W-1:0]    now_q;
	logic [SLOTS-1:0]     upload_q;
	logic [SLOTS-1:0]     start_q;
	logic [SLOTS-1:0]     stop_q;
	logic [SLOTS-1:0]     playing_q;
	logic [COUNT_W-1:0]   repeats_q [SLOTS];
	logic [TIME_W-1:0]    started_q [SLOTS];
	logic [DUR_W-1:0]     length_q  [SLOTS];

	logic [IDX_W-1:0]     item_idx;
	logic [WIDE_W-1:0]    wide_period;
	logic [PERIOD_W-1:0]  period;
	logic [TIME_W-1:0]    elapsed;
	logic                 expired;
	logic                 need;
	logic                 take;

	assign item_idx    = item.slot[IDX_W-1:0];
	assign wide_period = WIDE_W'(base_q) << shift_q;
	assign period      = (|wide_period[WIDE_W-1:PERIOD_W]) ? '1 : wide_period[PERIOD_W-1:0];
	assign elapsed     = now_q - started_q[idx_q];
	assign expired     = playing_q[idx_q] && (elapsed >= TIME_W'(length_q[idx_q]));
	assign need        = start_q[idx_q] || stop_q[idx_q];
	assign take        = (state_q == ST_IDLE) && item_valid && !res_full;
	assign item_pop    = take;

	always_comb begin
		res.command        = CMD_ACCEPTED;
		res.effect_slot    = '0;
		res.next_period_ms = '0;
		res.keep_running   = 1'b0;
		res.last           = 1'b0;
		res_push           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					res.last = 1'b1;
					case (item.kind)
						KIND_WALK: res_push = 1'b0;
						KIND_BACKOFF: begin
							res_push           = 1'b1;
							res.command        = CMD_BACKOFF;
							res.next_period_ms = period;
							res.keep_running   = 1'b1;
						end
						KIND_REJECT: begin
							res_push        = 1'b1;
							res.command     = CMD_REJECTED;
							res.effect_slot = item.slot;
						end
						default: begin
							res_push        = 1'b1;
							res.effect_slot = item.slot;
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (need && !res_full) begin
					res_push        = 1'b1;
					res.effect_slot = SLOT_W'(idx_q);
					if (upload_q[idx_q]) res.command = CMD_UPLOAD;
					else if (start_q[idx_q]) res.command = CMD_PLAY;
					else res.command = CMD_STOP;
				end
			end
			ST_FINAL: begin
				if (!res_full) begin
					res_push           = 1'b1;
					res.next_period_ms = period;
					res.keep_running   = (active_q != '0);
					res.last           = 1'b1;
				end
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= BASE_W'(8);
			shift_q   <= '0;
			active_q  <= '0;
			highest_q <= '0;
			idx_q     <= '0;
			now_q     <= '0;
			upload_q  <= '0;
			start_q   <= '0;
			stop_q    <= '0;
			playing_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				repeats_q[i] <= '0;
				started_q[i] <= '0;
				length_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) base_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (item.kind)
							KIND_UPLOAD: begin
								if (item_idx > highest_q) highest_q <= item_idx;
								length_q[item_idx] <= item.dur;
								upload_q[item_idx] <= 1'b1;
							end
							KIND_PLAY: begin
								if (playing_q[item_idx]) stop_q[item_idx] <= 1'b1;
								else if (active_q != '1) active_q <= active_q + ACTIVE_W'(1);
								repeats_q[item_idx] <= item.count;
								start_q[item_idx]   <= 1'b1;
							end
							KIND_HALT: begin
								stop_q[item_idx] <= 1'b1;
								if (active_q != '0) active_q <= active_q - ACTIVE_W'(1);
							end
							KIND_STOP: stop_q[item_idx] <= 1'b1;
							KIND_BACKOFF: begin
								if (shift_q != '1) shift_q <= shift_q + SHIFT_W'(1);
							end
							KIND_WALK: begin
								now_q   <= item.now;
								idx_q   <= '0;
								state_q <= ST_EXPIRE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EXPIRE: begin
					if (expired) begin
						playing_q[idx_q] <= 1'b0;
						if (repeats_q[idx_q] != '0) begin
							start_q[idx_q]   <= 1'b1;
							repeats_q[idx_q] <= repeats_q[idx_q] - COUNT_W'(1);
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!need) begin
						if (idx_q == highest_q) begin
							state_q <= ST_FINAL;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_EXPIRE;
						end
					end else if (!res_full) begin
						if (upload_q[idx_q]) begin
							upload_q[idx_q]  <= 1'b0;
							playing_q[idx_q] <= 1'b0;
						end else if (start_q[idx_q]) begin
							start_q[idx_q]   <= 1'b0;
							playing_q[idx_q] <= 1'b1;
							started_q[idx_q] <= now_q;
						end else begin
							stop_q[idx_q]    <= 1'b0;
							playing_q[idx_q] <= 1'b0;
						end
					end
				end
				ST_FINAL: begin
					if (!res_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_EXPIRE) |-> (idx_q <= highest_q))
		else $error("slot walk past highest slot");
	a_final_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && state_q == ST_FINAL) |=> (state_q == ST_IDLE))
		else $error("walk did not end after final transfer");
	a_emit_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && state_q == ST_EMIT) |-> !res.last)
		else $error("slot command marked last");
`endif

endmodule
`default_nettype wire

### design/esched_outq.sv
`default_nettype none
module esched_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire esched_pkg::result_t  wdata,
	output logic                      full,
	output logic                      empty,
	input  wire logic                 pop,
	output esched_pkg::result_t       head
);
	import esched_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	result_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               wr_en;
	logic               rd_en;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("result dropped on full queue");
`endif

endmodule
`default_nettype wire

### design/effect_slot_scheduler_unit.sv
// channel   direction  transfer condition    payload
// input     in         push & !full          action slot repeat_count duration_ms
//                                            zero_period_periodic now_ms link_busy
// result    out        pop & !empty          command effect_slot next_period_ms
//                                            keep_running last
// config    in         cfg_we                cfg_wdata (base_period_ms)
//
// upload, play, stop, busy tick: one result from the slot engine
// idle tick: taken in idle, then an expire and an emit step per slot up to the highest
// uploaded slot, one emit per command and a final result; the slot walk sequencer sets this
// reset: asynchronous, clears all slot state at once, no clearing pass
// stalls: a full result queue holds the slot engine; input taken while the
// 2-entry item queue has room
`default_nettype none
module effect_slot_scheduler_unit #(
	parameter int SLOTS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [esched_pkg::BASE_W-1:0]   cfg_wdata,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [esched_pkg::ACTION_W-1:0] action,
	input  wire logic [esched_pkg::SLOT_W-1:0]   slot,
	input  wire logic [esched_pkg::COUNT_W-1:0]  repeat_count,
	input  wire logic [esched_pkg::DUR_W-1:0]    duration_ms,
	input  wire logic                            zero_period_periodic,
	input  wire logic [esched_pkg::TIME_W-1:0]   now_ms,
	input  wire logic                            link_busy,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [esched_pkg::CMD_W-1:0]         command,
	output logic [esched_pkg::SLOT_W-1:0]        effect_slot,
	output logic [esched_pkg::PERIOD_W-1:0]      next_period_ms,
	output logic                                 keep_running,
	output logic                                 last
);
	import esched_pkg::*;

	item_t    item;
	logic     item_valid;
	logic     item_pop;
	result_t  res;
	logic     res_push;
	logic     res_full;
	result_t  head;

	esched_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.action               (action),
		.slot                 (slot),
		.repeat_count         (repeat_count),
		.duration_ms          (duration_ms),
		.zero_period_periodic (zero_period_periodic),
		.now_ms               (now_ms),
		.link_busy            (link_busy),
		.item                 (item),
		.item_valid           (item_valid),
		.item_pop             (item_pop)
	);

	esched_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.res        (res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	esched_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign command        = head.command;
	assign effect_slot    = head.effect_slot;
	assign next_period_ms = head.next_period_ms;
	assign keep_running   = head.keep_running;
	assign last           = head.last;

endmodule
`default_nettype wire

### tb/effect_command_checker.sv
`timescale 1ns / 100ps
module effect_command_checker #(
	parameter int SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [esched_pkg::BASE_W-1:0]   cfg_wdata,
	input  logic                            push,
	input  logic                            full,
	input  logic [esched_pkg::ACTION_W-1:0] action,
	input  logic [esched_pkg::SLOT_W-1:0]   slot,
	input  logic [esched_pkg::COUNT_W-1:0]  repeat_count,
	input  logic [esched_pkg::DUR_W-1:0]    duration_ms,
	input  logic                            zero_period_periodic,
	input  logic [esched_pkg::TIME_W-1:0]   now_ms,
	input  logic                            link_busy,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [esched_pkg::CMD_W-1:0]    command,
	input  logic [esched_pkg::SLOT_W-1:0]   effect_slot,
	input  logic [esched_pkg::PERIOD_W-1:0] next_period_ms,
	input  logic                            keep_running,
	input  logic                            last,
	output int                              errors,
	output int                              outstanding
);
	import esched_pkg::*;

	result_t expected_cmds[$];

	logic                upload_due[SLOTS];
	logic                start_due[SLOTS];
	logic                stop_due[SLOTS];
	logic                running[SLOTS];
	logic [COUNT_W-1:0]  repeats[SLOTS];
	logic [TIME_W-1:0]   began[SLOTS];
	logic [DUR_W-1:0]    length[SLOTS];
	logic [SLOT_W-1:0]   top_slot;
	logic [ACTIVE_W-1:0] in_use;
	logic [SHIFT_W-1:0]  shift;
	logic [BASE_W-1:0]   base_period;
	int                  results_seen;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 20) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	function automatic logic [PERIOD_W-1:0] tick_period();
		logic [BASE_W+14:0] wide;
		wide = {15'b0, base_period} << shift;
		return (wide > 'hFFFF) ? '1 : wide[PERIOD_W-1:0];
	endfunction

	function automatic void queue_cmd(input command_t c, input logic [SLOT_W-1:0] s,
		input logic [PERIOD_W-1:0] p, input logic k, input logic l);
		result_t r;
		r.command        = c;
		r.effect_slot    = s;
		r.next_period_ms = p;
		r.keep_running   = k;
		r.last           = l;
		expected_cmds.push_back(r);
	endfunction

	task automatic clear_state();
		for (int i = 0; i < SLOTS; i++) begin
			upload_due[i] = 1'b0;
			start_due[i]  = 1'b0;
			stop_due[i]   = 1'b0;
			running[i]    = 1'b0;
			repeats[i]    = '0;
			began[i]      = '0;
			length[i]     = '0;
		end
		top_slot     = '0;
		in_use       = '0;
		shift        = '0;
		base_period  = BASE_W'(8);
		results_seen = 0;
		errors       = 0;
		expected_cmds.delete();
	endtask

	task automatic predict_commands(input logic [ACTION_W-1:0] act,
		input logic [SLOT_W-1:0] s, input logic [COUNT_W-1:0] cnt,
		input logic [DUR_W-1:0] dur, input logic zpp, input logic [TIME_W-1:0] now,
		input logic busy);
		logic [TIME_W-1:0] age;
		if (act != ACT_TICK) begin
			if (s >= SLOTS || (act == ACT_UPLOAD && zpp)) begin
				queue_cmd(CMD_REJECTED, s, '0, 1'b0, 1'b1);
			end else begin
				case (act)
					ACT_UPLOAD: begin
						if (s > top_slot)
							top_slot = s;
						length[s]     = dur;
						upload_due[s] = 1'b1;
					end
					ACT_PLAY: begin
						if (cnt != 0) begin
							if (running[s])
								stop_due[s] = 1'b1;
							else if (in_use != '1)
								in_use++;
							repeats[s]   = cnt;
							start_due[s] = 1'b1;
						end else begin
							stop_due[s] = 1'b1;
							if (in_use != 0)
								in_use--;
						end
					end
					default: stop_due[s] = 1'b1;
				endcase
				queue_cmd(CMD_ACCEPTED, s, '0, 1'b0, 1'b1);
			end
		end else if (busy) begin
			queue_cmd(CMD_BACKOFF, '0, tick_period(), 1'b1, 1'b1);
			if (shift != '1)
				shift++;
		end else begin
			for (int i = 0; i <= top_slot && i < SLOTS; i++) begin
				age = now - began[i];
				if (running[i] && age >= TIME_W'(length[i])) begin
					running[i] = 1'b0;
					if (repeats[i] != 0) begin
						start_due[i] = 1'b1;
						repeats[i]--;
					end
				end
				if (!start_due[i] && !stop_due[i])
					continue;
				if (upload_due[i]) begin
					upload_due[i] = 1'b0;
					running[i]    = 1'b0;
					queue_cmd(CMD_UPLOAD, SLOT_W'(i), '0, 1'b0, 1'b0);
				end
				if (start_due[i]) begin
					start_due[i] = 1'b0;
					running[i]   = 1'b1;
					began[i]     = now;
					queue_cmd(CMD_PLAY, SLOT_W'(i), '0, 1'b0, 1'b0);
				end
				if (stop_due[i]) begin
					stop_due[i] = 1'b0;
					running[i]  = 1'b0;
					queue_cmd(CMD_STOP, SLOT_W'(i), '0, 1'b0, 1'b0);
				end
			end
			queue_cmd(CMD_ACCEPTED, '0, tick_period(), in_use != 0, 1'b1);
		end
	endtask

	task automatic check_command();
		result_t want;
		results_seen++;
		if (expected_cmds.size() == 0) begin
			report_mismatch($sformatf("result %0d unexpected: cmd %0d slot %0d last %0b",
				results_seen, command, effect_slot, last));
		end else begin
			want = expected_cmds.pop_front();
			if (command !== want.command || effect_slot !== want.effect_slot ||
				next_period_ms !== want.next_period_ms ||
				keep_running !== want.keep_running || last !== want.last) begin
				report_mismatch($sformatf(
					"result %0d: got %0d/%0d/%0d/%0b/%0b expected %0d/%0d/%0d/%0b/%0b",
					results_seen, command, effect_slot, next_period_ms, keep_running,
					last, want.command, want.effect_slot, want.next_period_ms,
					want.keep_running, want.last));
			end
		end
	endtask

	// inputs are sampled as they stood before the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we)
				base_period = cfg_wdata;
			if (push && !full)
				predict_commands(action, slot, repeat_count, duration_ms,
					zero_period_periodic, now_ms, link_busy);
			if (pop && !empty)
				check_command();
		end
		outstanding = expected_cmds.size();
	end

endmodule

### tb/effect_slot_scheduler_unit_tb.sv
`timescale 1ns / 100ps
module effect_slot_scheduler_unit_tb;
	import esched_pkg::*;

	logic                clk                  = 1'b0;
	logic                arst_n               = 1'b0;
	logic                cfg_we               = 1'b0;
	logic [BASE_W-1:0]   cfg_wdata            = '0;
	logic                push                 = 1'b0;
	logic [ACTION_W-1:0] action               = '0;
	logic [SLOT_W-1:0]   slot                 = '0;
	logic [COUNT_W-1:0]  repeat_count         = '0;
	logic [DUR_W-1:0]    duration_ms          = '0;
	logic                zero_period_periodic = 1'b0;
	logic [TIME_W-1:0]   now_ms               = '0;
	logic                link_busy            = 1'b0;
	logic                pop                  = 1'b0;
	logic                full;
	logic                empty;
	logic [CMD_W-1:0]    command;
	logic [SLOT_W-1:0]   effect_slot;
	logic [PERIOD_W-1:0] next_period_ms;
	logic                keep_running;
	logic                last;

	int                  mismatches;
	int                  outstanding;
	int                  burst_left = 0;
	logic [TIME_W-1:0]   clock_ms   = '0;
	bit                  squeeze    = 1'b0;

	effect_slot_scheduler_unit #(
		.SLOTS(16)
	) DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.push                 (push),
		.full                 (full),
		.action               (action),
		.slot                 (slot),
		.repeat_count         (repeat_count),
		.duration_ms          (duration_ms),
		.zero_period_periodic (zero_period_periodic),
		.now_ms               (now_ms),
		.link_busy            (link_busy),
		.empty                (empty),
		.pop                  (pop),
		.command              (command),
		.effect_slot          (effect_slot),
		.next_period_ms       (next_period_ms),
		.keep_running         (keep_running),
		.last                 (last)
	);

	effect_command_checker #(
		.SLOTS(16)
	) cmd_check (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.push                 (push),
		.full                 (full),
		.action               (action),
		.slot                 (slot),
		.repeat_count         (repeat_count),
		.duration_ms          (duration_ms),
		.zero_period_periodic (zero_period_periodic),
		.now_ms               (now_ms),
		.link_busy            (link_busy),
		.empty                (empty),
		.pop                  (pop),
		.command              (command),
		.effect_slot          (effect_slot),
		.next_period_ms       (next_period_ms),
		.keep_running         (keep_running),
		.last                 (last),
		.errors               (mismatches),
		.outstanding          (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("effect_slot_scheduler_unit_tb: FAIL");
		$finish;
	end

	// bursts of items with random gaps, some bursts back to back
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic offer(input action_t a, input logic [SLOT_W-1:0] s,
		input logic [COUNT_W-1:0] cnt, input logic [DUR_W-1:0] dur, input logic zpp,
		input logic [TIME_W-1:0] now, input logic busy);
		action               <= a;
		slot                 <= s;
		repeat_count         <= cnt;
		duration_ms          <= dur;
		zero_period_periodic <= zpp;
		now_ms               <= now;
		link_busy            <= busy;
		push                 <= 1'b1;
		do @(negedge clk); while (full);
		@(posedge clk);
		pace();
	endtask

	task automatic offer_random();
		int                 pick;
		logic [SLOT_W-1:0]  s;
		logic [COUNT_W-1:0] cnt;
		logic [DUR_W-1:0]   dur;
		pick = $urandom_range(0, 99);
		s = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 15)) :
			SLOT_W'($urandom_range(0, 5));
		if (pick < 30) begin
			clock_ms = clock_ms + $urandom_range(0, 6);
			offer(ACT_TICK, SLOT_W'($urandom), COUNT_W'($urandom), DUR_W'($urandom),
				1'($urandom), clock_ms, $urandom_range(0, 24) == 0);
		end else if (pick < 50) begin
			dur = ($urandom_range(0, 7) == 0) ? DUR_W'($urandom) :
				DUR_W'($urandom_range(0, 12));
			offer(ACT_UPLOAD, s, COUNT_W'($urandom), dur, $urandom_range(0, 9) == 0,
				$urandom, 1'($urandom));
		end else if (pick < 80) begin
			pick = $urandom_range(0, 99);
			cnt = (pick < 10) ? '0 : (pick < 85) ? COUNT_W'($urandom_range(1, 3)) :
				COUNT_W'($urandom);
			offer(ACT_PLAY, s, cnt, DUR_W'($urandom), 1'($urandom), $urandom,
				1'($urandom));
		end else if (pick < 90) begin
			offer(ACT_STOP, s, COUNT_W'($urandom), DUR_W'($urandom), 1'($urandom),
				$urandom, 1'($urandom));
		end else begin
			offer(action_t'(ACTION_W'($urandom_range(0, 3))), SLOT_W'($urandom),
				COUNT_W'($urandom), DUR_W'($urandom), 1'($urandom), $urandom,
				1'($urandom));
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic set_base(input logic [BASE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// receiver: a random stall pattern from a 16-bit mask, one long hold-off on request
	initial begin
		logic [15:0] mask;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (squeeze && !held) begin
				held = 1'b1;
				@(posedge clk);
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: mask = '1;
				1: mask = 16'($urandom);
				2: mask = 16'($urandom | $urandom);
				default: mask = 16'($urandom & $urandom);
			endcase
			for (int k = 0; k < 16; k++) begin
				@(posedge clk);
				pop <= mask[k];
			end
		end
	end

	initial begin
		logic [BASE_W-1:0] base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_UPLOAD, 4'd0, 8'hFF, 16'hFFFF, 1'b1, '1, 1'b1);
		offer(ACT_UPLOAD, 4'd15, 8'd0, 16'hFFFF, 1'b0, 32'd0, 1'b0);
		offer(ACT_UPLOAD, 4'd3, 8'd0, 16'd5, 1'b0, 32'd0, 1'b0);
		// uploads alone wait for a start or stop
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd1, 1'b0);
		offer(ACT_PLAY, 4'd3, 8'd2, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_STOP, 4'd15, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_PLAY, 4'd15, 8'hFF, 16'd0, 1'b0, 32'd0, 1'b0);
		// upload, play and stop all on the highest slot
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd10, 1'b0);
		// expiry re-arms while repeats remain
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd16, 1'b0);
		offer(ACT_PLAY, 4'd3, 8'd1, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd0, 1'b1);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd0, 1'b1);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd17, 1'b0);
		offer(ACT_PLAY, 4'd3, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_PLAY, 4'd0, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		// active count already at zero
		offer(ACT_PLAY, 4'd7, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_UPLOAD, 4'd9, 8'd0, 16'd3, 1'b0, 32'd0, 1'b0);
		offer(ACT_PLAY, 4'd9, 8'd1, 16'd0, 1'b0, 32'd0, 1'b0);
		// time wraps between start and expiry
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'hFFFF_FFFE, 1'b0);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'd2, 1'b0);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		offer(ACT_STOP, 4'd9, 8'd0, 16'd0, 1'b0, 32'd0, 1'b0);
		offer(ACT_TICK, 4'd0, 8'd0, 16'd0, 1'b0, '1, 1'b0);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: base = BASE_W'(1000);
				1: base = BASE_W'(1);
				2: base = '0;
				3: base = '1;
				default: base = BASE_W'($urandom_range(2, 999));
			endcase
			set_base(base);
			clock_ms = (ph == 3) ? 32'hFFFF_FFC0 : $urandom;
			for (int n = 0; n < 47; n++) begin
				if (ph == 1 && n == 10)
					squeeze = 1'b1;
				offer_random();
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("effect_slot_scheduler_unit_tb: PASS");
		else
			$display("effect_slot_scheduler_unit_tb: FAIL");
		$finish;
	end

endmodule

### files.f
design/esched_pkg.sv
design/esched_front.sv
design/esched_back.sv
design/esched_outq.sv
design/effect_slot_scheduler_unit.sv
tb/effect_command_checker.sv
tb/effect_slot_scheduler_unit_tb.sv
